// File: rtl/core/fcl_pkg.sv
package fcl_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] CFG_DATA_START  = 2'd0;
  localparam logic [1:0] CFG_SEC_PER_CLU = 2'd1;
  localparam logic [1:0] CFG_TABLE_LEN   = 2'd2;

  localparam logic [15:0] DATA_START_RST  = 16'd33;
  localparam logic [7:0]  SEC_PER_CLU_RST = 8'd1;
  localparam logic [13:0] TABLE_LEN_RST   = 14'd4608;

  localparam logic [11:0] ENTRY_MASK    = 12'hFFF;
  localparam logic [11:0] CHAIN_END_MIN = 12'hFF8;
  localparam logic [19:0] SECTOR_MAX    = 20'hFFFFF;
  localparam logic [11:0] FIRST_CLUSTER = 12'd2;

  typedef struct packed {
    logic        cmd;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] cluster;
  } in_item_t;

  typedef struct packed {
    logic [19:0] sector_address;
    logic [11:0] next_cluster;
    logic        chain_end;
    logic        bad_lookup;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic mem_we;     // write the load item's byte
    logic item_load;  // capture a lookup item
    logic rd_lo;      // read the entry's first byte, form the product
    logic rd_hi;      // read the entry's second byte, keep the first
    logic out_load;   // move the finished result to the output register
  } fcl_cmd_t;

endpackage

// File: rtl/core/fat12_cluster_chain_lookup.sv
// FAT12 cluster chain lookup. A load item (cmd 0) writes one byte of the
// allocation table into a byte store (one write port, one read port) and is
// done in the cycle it is accepted; it gives no result. A lookup item (cmd 1)
// reads the two table bytes that hold the cluster's packed 12-bit entry, one
// per cycle through the store's read port, while the sector multiply runs
// alongside; no new item is taken until the result has entered the output
// register, which may wait while that register is still occupied. Results
// wait in the output register, and loads and lookups are taken meanwhile.
// bad_lookup flags clusters below 2 and entries that reach past the smaller of
// table_length and TABLE_BYTES; the other result fields are then zero.
// Sector addresses saturate at 0xFFFFF. Table bytes read before they were
// loaded give undefined entries.
module fat12_cluster_chain_lookup #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fcl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output fcl_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import fcl_pkg::*;

  fcl_cmd_t ctl;

  fcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  fcl_dp #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/fcl_ctrl.sv
module fcl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output fcl_pkg::fcl_cmd_t ctl
);
  import fcl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD0  = 2'd1;
  localparam logic [1:0] S_RD1  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_LOOKUP) begin
            ctl.item_load = 1'b1;
            state_nxt     = S_RD0;
          end else begin
            ctl.mem_we = 1'b1;
          end
        end
      end
      S_RD0: begin
        ctl.rd_lo = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        ctl.rd_hi = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/fcl_dp.sv
module fcl_dp #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcl_pkg::fcl_cmd_t  ctl,
  input  fcl_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output fcl_pkg::out_item_t out_item
);
  import fcl_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);
  localparam logic [13:0] TB_LIMIT = 14'(TABLE_BYTES);

  logic [7:0]  mem [TABLE_BYTES];
  logic [7:0]  rdata_r;
  logic [7:0]  lo_r;
  logic [15:0] dsl_r;
  logic [7:0]  spc_r;
  logic [13:0] tlen_r;
  logic [11:0] clus_r;
  logic [12:0] pos_r;
  logic        bad_r;
  logic [19:0] prod_r;
  out_item_t   out_r;

  logic [13:0] clus3;
  logic [12:0] pos;
  logic [13:0] pos1;
  logic [13:0] limit;
  logic        in_range;
  logic        mem_re;
  logic [12:0] raddr;
  logic [11:0] clus_off;
  logic [20:0] sum;
  logic [15:0] word;
  logic [11:0] next;
  out_item_t   res;

  assign clus3    = 14'(in_item.cluster) + 14'({in_item.cluster, 1'b0});
  assign pos      = clus3[13:1];
  assign pos1     = 14'(pos) + 14'd1;
  assign limit    = (tlen_r > TB_LIMIT) ? TB_LIMIT : tlen_r;
  assign in_range = ({1'b0, in_item.byte_index} < TB_LIMIT);

  assign mem_re   = ctl.rd_lo || ctl.rd_hi;
  assign raddr    = ctl.rd_hi ? 13'(pos_r + 13'd1) : pos_r;

  always_ff @(posedge clk) begin
    if (ctl.mem_we && in_range) begin
      mem[in_item.byte_index[AW-1:0]] <= in_item.byte_value;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsl_r  <= DATA_START_RST;
      spc_r  <= SEC_PER_CLU_RST;
      tlen_r <= TABLE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_START:  dsl_r  <= cfg_data;
        CFG_SEC_PER_CLU: spc_r  <= cfg_data[7:0];
        CFG_TABLE_LEN:   tlen_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign clus_off = clus_r - FIRST_CLUSTER;

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      clus_r <= in_item.cluster;
      pos_r  <= pos;
      bad_r  <= (in_item.cluster < FIRST_CLUSTER) || (pos1 >= limit);
    end
    if (ctl.rd_lo) begin
      prod_r <= 20'(clus_off * spc_r);
    end
    if (ctl.rd_hi) begin
      lo_r <= rdata_r;
    end
    if (ctl.out_load) begin
      out_r <= res;
    end
  end

  // in the result state rdata_r holds the entry's second byte
  assign sum  = 21'(dsl_r) + 21'(prod_r);
  assign word = {rdata_r, lo_r};
  assign next = clus_r[0] ? (word[15:4] & ENTRY_MASK) : (word[11:0] & ENTRY_MASK);

  always_comb begin
    res = '0;
    if (bad_r) begin
      res.bad_lookup = 1'b1;
    end else begin
      res.sector_address = sum[20] ? SECTOR_MAX : sum[19:0];
      res.next_cluster   = next;
      res.chain_end      = (next >= CHAIN_END_MIN);
    end
  end

  assign out_item = out_r;

endmodule

// File: rtl/core/fcl_checker.sv
module fcl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fcl_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input fcl_pkg::out_item_t out_item
);
  import fcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.cmd == CMD_LOOKUP |=> in_stall)
    else $error("new item taken during a lookup");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.cmd == CMD_LOAD |=> !in_stall)
    else $error("load item did not complete in one cycle");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bad_lookup |->
      out_item.sector_address == '0 && out_item.next_cluster == '0 &&
      !out_item.chain_end)
    else $error("bad lookup carries nonzero fields");

  a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.bad_lookup |->
      out_item.chain_end == (out_item.next_cluster >= CHAIN_END_MIN))
    else $error("chain_end disagrees with next_cluster");

endmodule

bind fat12_cluster_chain_lookup fcl_checker u_fcl_checker (.*);
